>>> design/tuft_pkg.sv
// Shared types and constants for the TCP/UDP flow statistics table.
package tuft_pkg;

   localparam logic [7:0] PROTO_TCP = 8'd6;
   localparam logic [7:0] PROTO_UDP = 8'd17;
   localparam int unsigned FLAG_FIN_BIT = 0;
   localparam int unsigned FLAG_SYN_BIT = 1;
   localparam logic [31:0] PKT_MAX = 32'hFFFF_FFFF;
   localparam logic [47:0] BYTE_MAX = 48'hFFFF_FFFF_FFFF;

   typedef enum logic [2:0] {
      ST_IGNORED  = 3'd0,
      ST_UPDATED  = 3'd1,
      ST_CREATED  = 3'd2,
      ST_REMOVED  = 3'd3,
      ST_NOT_SYN  = 3'd4,
      ST_FULL     = 3'd5,
      ST_REPORTED = 3'd6,
      ST_EMPTY    = 3'd7
   } status_type;

   // Commands from controller to datapath.
   typedef struct packed {
      logic       load;       // capture request fields
      logic       scan_rd;    // issue memory read at scan index
      logic       scan_chk;   // compare read data with key
      logic       rd_entry;   // issue memory read at chosen slot
      logic       do_update;  // write counters into hit slot
      logic       do_create;  // write new entry into free slot
      logic       do_remove;  // clear valid of hit slot
      logic       do_report;  // build read response
      logic       set_status; // load status into response
      status_type status;
   } cmd_type;

   typedef struct packed {
      logic func;
      logic other_proto;
      logic is_tcp;
      logic fin;
      logic syn;
      logic hit;
      logic has_free;
      logic scan_last;
   } sts_type;

endpackage

>>> design/tuft_datapath.sv
// Flow table storage, key scan, counter update and response registers.
module tuft_datapath import tuft_pkg::*; #(
   parameter int FLOW_ENTRIES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output sts_type     sts,
   input  logic        req_func,
   input  logic [31:0] req_src_ip,
   input  logic [31:0] req_dst_ip,
   input  logic [15:0] req_sport,
   input  logic [15:0] req_dport,
   input  logic [7:0]  req_protocol,
   input  logic [7:0]  req_tcp_flags,
   input  logic [15:0] req_ip_length,
   input  logic [63:0] req_timestamp,
   input  logic [5:0]  req_entry_index,
   input  logic        req_want_tcp,
   input  logic        req_want_udp,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_flow_src_ip,
   output logic [31:0] rsp_flow_dst_ip,
   output logic [15:0] rsp_flow_sport,
   output logic [15:0] rsp_flow_dport,
   output logic [7:0]  rsp_flow_protocol,
   output logic [31:0] rsp_packet_count,
   output logic [47:0] rsp_byte_count,
   output logic [63:0] rsp_flow_age,
   output logic [7:0]  rsp_flag_union
);

   localparam int IW = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
   localparam int CW = $clog2(FLOW_ENTRIES + 1);

   typedef struct packed {
      logic [63:0] addr;
      logic [31:0] ports;
      logic [7:0]  proto;
      logic [63:0] first;
      logic [63:0] last;
      logic [31:0] pkts;
      logic [47:0] bytes;
      logic [7:0]  flags;
   } entry_type;

   entry_type mem [FLOW_ENTRIES];
   entry_type rdata_ff;
   logic [FLOW_ENTRIES-1:0] valid_ff;

   logic        func_ff;
   logic [63:0] key_addr_ff;
   logic [31:0] key_ports_ff;
   logic [7:0]  proto_ff;
   logic [7:0]  flags_ff;
   logic [15:0] len_ff;
   logic [63:0] time_ff;
   logic        want_tcp_ff;
   logic        want_udp_ff;

   logic [CW-1:0] scan_ff;     // next slot to read
   logic [IW-1:0] chk_ff;      // slot whose data sits in rdata_ff
   logic          hit_ff;
   logic [IW-1:0] hit_idx_ff;
   logic          free_ff;
   logic [IW-1:0] free_idx_ff;
   logic          rd_ok_ff;

   logic [IW-1:0] rd_addr;
   logic [IW-1:0] wr_idx;
   entry_type     wr_data;
   logic [32:0]   pkt_sum;
   logic [48:0]   byte_sum;
   logic [7:0]    add_flags;
   logic          is_tcp;
   logic          chk_valid;

   assign is_tcp = (proto_ff == PROTO_TCP);
   assign add_flags = is_tcp ? flags_ff : 8'd0;
   assign rd_addr = cmd.rd_entry ? hit_idx_ff : scan_ff[IW-1:0];
   assign chk_valid = valid_ff[chk_ff];

   always_comb begin
      entry_type base;
      base = rdata_ff;
      wr_idx = hit_idx_ff;
      if (cmd.do_create) begin
         wr_idx = free_idx_ff;
         base.addr = key_addr_ff;
         base.ports = key_ports_ff;
         base.proto = proto_ff;
         base.first = time_ff;
         base.pkts = 32'd0;
         base.bytes = 48'd0;
         base.flags = 8'd0;
      end
      pkt_sum = {1'b0, base.pkts} + 33'd1;
      byte_sum = {1'b0, base.bytes} + {33'd0, len_ff};
      wr_data = base;
      wr_data.last = time_ff;
      wr_data.pkts = (base.pkts == PKT_MAX) ? PKT_MAX : pkt_sum[31:0];
      wr_data.bytes = byte_sum[48] ? BYTE_MAX : byte_sum[47:0];
      wr_data.flags = base.flags | add_flags;
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem[rd_addr];
      if (cmd.do_update || cmd.do_create) begin
         mem[wr_idx] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.do_create) begin
         valid_ff[free_idx_ff] <= 1'b1;
      end else if (cmd.do_remove) begin
         valid_ff[hit_idx_ff] <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= req_func;
         key_addr_ff <= {req_src_ip, req_dst_ip};
         key_ports_ff <= {req_sport, req_dport};
         proto_ff <= req_protocol;
         flags_ff <= req_tcp_flags;
         len_ff <= req_ip_length;
         time_ff <= req_timestamp;
         want_tcp_ff <= req_want_tcp;
         want_udp_ff <= req_want_udp;
         scan_ff <= '0;
         hit_ff <= 1'b0;
         free_ff <= 1'b0;
         hit_idx_ff <= IW'(req_entry_index);
         rd_ok_ff <= ({26'd0, req_entry_index} < 32'(FLOW_ENTRIES));
      end else begin
         if (cmd.scan_rd) begin
            chk_ff <= scan_ff[IW-1:0];
            scan_ff <= scan_ff + CW'(1);
         end
         if (cmd.scan_chk) begin
            if (chk_valid) begin
               if (!hit_ff && rdata_ff.addr == key_addr_ff && rdata_ff.ports == key_ports_ff
                   && rdata_ff.proto == proto_ff) begin
                  hit_ff <= 1'b1;
                  hit_idx_ff <= chk_ff;
               end
            end else if (!free_ff) begin
               free_ff <= 1'b1;
               free_idx_ff <= chk_ff;
            end
         end
      end
   end

   // Response registers; fields other than status stay zero unless reporting.
   always_ff @(posedge clock) begin
      if (cmd.set_status) begin
         rsp_status <= cmd.status;
         rsp_flow_src_ip <= '0;
         rsp_flow_dst_ip <= '0;
         rsp_flow_sport <= '0;
         rsp_flow_dport <= '0;
         rsp_flow_protocol <= '0;
         rsp_packet_count <= '0;
         rsp_byte_count <= '0;
         rsp_flow_age <= '0;
         rsp_flag_union <= '0;
      end else if (cmd.do_report) begin
         if (rd_ok_ff && valid_ff[hit_idx_ff]
             && ((rdata_ff.proto == PROTO_TCP && want_tcp_ff)
                 || (rdata_ff.proto == PROTO_UDP && want_udp_ff))) begin
            rsp_status <= ST_REPORTED;
            rsp_flow_src_ip <= rdata_ff.addr[63:32];
            rsp_flow_dst_ip <= rdata_ff.addr[31:0];
            rsp_flow_sport <= rdata_ff.ports[31:16];
            rsp_flow_dport <= rdata_ff.ports[15:0];
            rsp_flow_protocol <= rdata_ff.proto;
            rsp_packet_count <= rdata_ff.pkts;
            rsp_byte_count <= rdata_ff.bytes;
            rsp_flow_age <= rdata_ff.last - rdata_ff.first;
            rsp_flag_union <= rdata_ff.flags;
         end else begin
            rsp_status <= ST_EMPTY;
            rsp_flow_src_ip <= '0;
            rsp_flow_dst_ip <= '0;
            rsp_flow_sport <= '0;
            rsp_flow_dport <= '0;
            rsp_flow_protocol <= '0;
            rsp_packet_count <= '0;
            rsp_byte_count <= '0;
            rsp_flow_age <= '0;
            rsp_flag_union <= '0;
         end
      end
   end

   assign sts.func = func_ff;
   assign sts.other_proto = (proto_ff != PROTO_TCP) && (proto_ff != PROTO_UDP);
   assign sts.is_tcp = is_tcp;
   assign sts.fin = flags_ff[FLAG_FIN_BIT];
   assign sts.syn = flags_ff[FLAG_SYN_BIT];
   assign sts.hit = hit_ff;
   assign sts.has_free = free_ff;
   assign sts.scan_last = (scan_ff == CW'(FLOW_ENTRIES - 1));

endmodule

>>> design/tuft_ctrl.sv
// Sequencing of lookup, update and read for the flow table.
module tuft_ctrl import tuft_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output cmd_type cmd,
   input  sts_type sts
);

   typedef enum logic [2:0] {
      S_IDLE, S_DECODE, S_SCAN, S_LAST, S_DECIDE, S_RDWAIT, S_ACT, S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff;

   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      cmd.status = ST_IGNORED;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (sts.func) begin
               cmd.rd_entry = 1'b1;
               state_in = S_RDWAIT;
            end else if (sts.other_proto) begin
               cmd.set_status = 1'b1;
               cmd.status = ST_IGNORED;
               state_in = S_DONE;
            end else begin
               cmd.scan_rd = 1'b1;
               state_in = sts.scan_last ? S_LAST : S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan_rd = 1'b1;
            cmd.scan_chk = 1'b1;
            if (sts.scan_last) state_in = S_LAST;
         end
         S_LAST: begin
            cmd.scan_chk = 1'b1;
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            priority if (sts.hit) begin
               if (sts.is_tcp && sts.fin) begin
                  cmd.do_remove = 1'b1;
                  cmd.set_status = 1'b1;
                  cmd.status = ST_REMOVED;
                  state_in = S_DONE;
               end else begin
                  cmd.rd_entry = 1'b1;
                  state_in = S_RDWAIT;
               end
            end else if (sts.is_tcp && !sts.syn) begin
               cmd.set_status = 1'b1;
               cmd.status = ST_NOT_SYN;
               state_in = S_DONE;
            end else if (!sts.has_free) begin
               cmd.set_status = 1'b1;
               cmd.status = ST_FULL;
               state_in = S_DONE;
            end else begin
               cmd.do_create = 1'b1;
               cmd.set_status = 1'b1;
               cmd.status = ST_CREATED;
               state_in = S_DONE;
            end
         end
         S_RDWAIT: begin
            // hold the read address on the chosen slot
            cmd.rd_entry = 1'b1;
            state_in = S_ACT;
         end
         S_ACT: begin
            if (sts.func) begin
               cmd.do_report = 1'b1;
            end else begin
               cmd.do_update = 1'b1;
               cmd.set_status = 1'b1;
               cmd.status = ST_UPDATED;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_DONE) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

>>> design/tcp_udp_flow_stats_table.sv
// A packet item does one key compare per slot through the single table read port; other
// protocols and reads do not scan.
// Throughput: one item at a time; the next is taken once the result is transferred.
// Reset: synchronous, clears all slot valid bits at once; no clearing pass.
// Stored fields of a slot are undefined until the slot is first created.
module tcp_udp_flow_stats_table import tuft_pkg::*; #(
   parameter int FLOW_ENTRIES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_func,
   input  logic [31:0] req_src_ip,
   input  logic [31:0] req_dst_ip,
   input  logic [15:0] req_sport,
   input  logic [15:0] req_dport,
   input  logic [7:0]  req_protocol,
   input  logic [7:0]  req_tcp_flags,
   input  logic [15:0] req_ip_length,
   input  logic [63:0] req_timestamp,
   input  logic [5:0]  req_entry_index,
   input  logic        req_want_tcp,
   input  logic        req_want_udp,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_flow_src_ip,
   output logic [31:0] rsp_flow_dst_ip,
   output logic [15:0] rsp_flow_sport,
   output logic [15:0] rsp_flow_dport,
   output logic [7:0]  rsp_flow_protocol,
   output logic [31:0] rsp_packet_count,
   output logic [47:0] rsp_byte_count,
   output logic [63:0] rsp_flow_age,
   output logic [7:0]  rsp_flag_union
);

   cmd_type cmd;
   sts_type sts;

   tuft_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready, .cmd, .sts
   );

   tuft_datapath #(.FLOW_ENTRIES(FLOW_ENTRIES)) u_dp (
      .clock, .reset, .cmd, .sts,
      .req_func, .req_src_ip, .req_dst_ip, .req_sport, .req_dport,
      .req_protocol, .req_tcp_flags, .req_ip_length, .req_timestamp,
      .req_entry_index, .req_want_tcp, .req_want_udp,
      .rsp_status, .rsp_flow_src_ip, .rsp_flow_dst_ip, .rsp_flow_sport,
      .rsp_flow_dport, .rsp_flow_protocol, .rsp_packet_count,
      .rsp_byte_count, .rsp_flow_age, .rsp_flag_union
   );

endmodule

>>> tb/tb_tcp_udp_flow_stats_table.sv
// Self-checking testbench for the TCP/UDP five-tuple flow statistics table.
module tb_tcp_udp_flow_stats_table import tuft_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_SLOTS   = 64;
   localparam int DRAIN_WAIT  = NUM_SLOTS + 16;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int KEY_POOL    = 80;

   typedef struct packed {
      logic        func;
      logic [31:0] src_ip;
      logic [31:0] dst_ip;
      logic [15:0] sport;
      logic [15:0] dport;
      logic [7:0]  protocol;
      logic [7:0]  tcp_flags;
      logic [15:0] ip_length;
      logic [63:0] timestamp;
      logic [5:0]  entry_index;
      logic        want_tcp;
      logic        want_udp;
   } pkt_item_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] src_ip;
      logic [31:0] dst_ip;
      logic [15:0] sport;
      logic [15:0] dport;
      logic [7:0]  protocol;
      logic [31:0] packets;
      logic [47:0] bytes;
      logic [63:0] age;
      logic [7:0]  flags;
   } flow_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_func = 1'b0;
   logic [31:0] req_src_ip = '0;
   logic [31:0] req_dst_ip = '0;
   logic [15:0] req_sport = '0;
   logic [15:0] req_dport = '0;
   logic [7:0]  req_protocol = '0;
   logic [7:0]  req_tcp_flags = '0;
   logic [15:0] req_ip_length = '0;
   logic [63:0] req_timestamp = '0;
   logic [5:0]  req_entry_index = '0;
   logic        req_want_tcp = 1'b0;
   logic        req_want_udp = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_status;
   logic [31:0] rsp_flow_src_ip;
   logic [31:0] rsp_flow_dst_ip;
   logic [15:0] rsp_flow_sport;
   logic [15:0] rsp_flow_dport;
   logic [7:0]  rsp_flow_protocol;
   logic [31:0] rsp_packet_count;
   logic [47:0] rsp_byte_count;
   logic [63:0] rsp_flow_age;
   logic [7:0]  rsp_flag_union;

   tcp_udp_flow_stats_table #(.FLOW_ENTRIES(NUM_SLOTS)) u_dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Predicted table contents
   logic        tbl_valid [NUM_SLOTS];
   logic [63:0] tbl_addr  [NUM_SLOTS];
   logic [31:0] tbl_ports [NUM_SLOTS];
   logic [7:0]  tbl_proto [NUM_SLOTS];
   logic [63:0] tbl_first [NUM_SLOTS];
   logic [63:0] tbl_last  [NUM_SLOTS];
   logic [31:0] tbl_pkts  [NUM_SLOTS];
   logic [47:0] tbl_bytes [NUM_SLOTS];
   logic [7:0]  tbl_flags [NUM_SLOTS];

   flow_result_type flow_expq[$];
   int errors = 0;
   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int hold_len = 0;
   logic hold_toggle = 1'b0;
   logic [63:0] now_ts = 64'd1000;

   logic [31:0] pool_sip [KEY_POOL];
   logic [31:0] pool_dip [KEY_POOL];
   logic [15:0] pool_sp  [KEY_POOL];
   logic [15:0] pool_dp  [KEY_POOL];
   logic [7:0]  pool_proto [KEY_POOL];

   function automatic void count_flow(int s, logic [63:0] ts, logic [15:0] len,
                                      logic [7:0] fl);
      logic [48:0] sum;
      sum = {1'b0, tbl_bytes[s]} + len;
      tbl_last[s] = ts;
      if (tbl_pkts[s] != PKT_MAX) tbl_pkts[s] = tbl_pkts[s] + 1;
      tbl_bytes[s] = sum[48] ? BYTE_MAX : sum[47:0];
      tbl_flags[s] = tbl_flags[s] | fl;
   endfunction

   function automatic flow_result_type predict_flow(pkt_item_type p);
      flow_result_type r;
      int s;
      int hit;
      int free_slot;
      logic tcp;
      logic [63:0] addr;
      logic [31:0] ports;
      r = '0;
      r.status = ST_EMPTY;
      if (p.func) begin
         s = p.entry_index;
         if (tbl_valid[s] && ((tbl_proto[s] == PROTO_TCP && p.want_tcp) ||
                              (tbl_proto[s] == PROTO_UDP && p.want_udp))) begin
            r.status   = ST_REPORTED;
            r.src_ip   = tbl_addr[s][63:32];
            r.dst_ip   = tbl_addr[s][31:0];
            r.sport    = tbl_ports[s][31:16];
            r.dport    = tbl_ports[s][15:0];
            r.protocol = tbl_proto[s];
            r.packets  = tbl_pkts[s];
            r.bytes    = tbl_bytes[s];
            r.age      = tbl_last[s] - tbl_first[s];
            r.flags    = tbl_flags[s];
         end
         return r;
      end
      if (p.protocol != PROTO_TCP && p.protocol != PROTO_UDP) begin
         r.status = ST_IGNORED;
         return r;
      end
      tcp = (p.protocol == PROTO_TCP);
      addr = {p.src_ip, p.dst_ip};
      ports = {p.sport, p.dport};
      hit = -1;
      free_slot = -1;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (tbl_valid[i]) begin
            if (hit < 0 && tbl_addr[i] == addr && tbl_ports[i] == ports &&
                tbl_proto[i] == p.protocol) hit = i;
         end else if (free_slot < 0) begin
            free_slot = i;
         end
      end
      if (hit >= 0) begin
         if (tcp && p.tcp_flags[FLAG_FIN_BIT]) begin
            tbl_valid[hit] = 1'b0;
            r.status = ST_REMOVED;
         end else begin
            count_flow(hit, p.timestamp, p.ip_length, tcp ? p.tcp_flags : 8'h00);
            r.status = ST_UPDATED;
         end
      end else if (tcp && !p.tcp_flags[FLAG_SYN_BIT]) begin
         r.status = ST_NOT_SYN;
      end else if (free_slot < 0) begin
         r.status = ST_FULL;
      end else begin
         tbl_valid[free_slot] = 1'b1;
         tbl_addr[free_slot]  = addr;
         tbl_ports[free_slot] = ports;
         tbl_proto[free_slot] = p.protocol;
         tbl_first[free_slot] = p.timestamp;
         tbl_pkts[free_slot]  = '0;
         tbl_bytes[free_slot] = '0;
         tbl_flags[free_slot] = '0;
         count_flow(free_slot, p.timestamp, p.ip_length, tcp ? p.tcp_flags : 8'h00);
         r.status = ST_CREATED;
      end
      return r;
   endfunction

   function automatic pkt_item_type make_pkt(logic [7:0] proto, logic [7:0] fl,
                                             logic [31:0] sip, logic [31:0] dip,
                                             logic [15:0] sp, logic [15:0] dp,
                                             logic [15:0] len, logic [63:0] ts);
      pkt_item_type p;
      p = '0;
      p.src_ip = sip;
      p.dst_ip = dip;
      p.sport = sp;
      p.dport = dp;
      p.protocol = proto;
      p.tcp_flags = fl;
      p.ip_length = len;
      p.timestamp = ts;
      return p;
   endfunction

   function automatic pkt_item_type make_read(logic [5:0] idx, logic wt, logic wu);
      pkt_item_type p;
      p = '0;
      p.func = 1'b1;
      p.entry_index = idx;
      p.want_tcp = wt;
      p.want_udp = wu;
      return p;
   endfunction

   task automatic send_item(pkt_item_type p);
      @(posedge clock);
      while ($urandom_range(99) < tx_idle_pct) @(posedge clock);
      req_valid       <= 1'b1;
      req_func        <= p.func;
      req_src_ip      <= p.src_ip;
      req_dst_ip      <= p.dst_ip;
      req_sport       <= p.sport;
      req_dport       <= p.dport;
      req_protocol    <= p.protocol;
      req_tcp_flags   <= p.tcp_flags;
      req_ip_length   <= p.ip_length;
      req_timestamp   <= p.timestamp;
      req_entry_index <= p.entry_index;
      req_want_tcp    <= p.want_tcp;
      req_want_udp    <= p.want_udp;
      do @(posedge clock); while (!req_ready);
      flow_expq.push_back(predict_flow(p));
      req_valid <= 1'b0;
   endtask

   task automatic wait_flows_idle();
      wait (flow_expq.size() == 0);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   // Receiver: random stalls, plus a long hold-off on request
   logic hold_seen = 1'b0;
   int   hold_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_seen != hold_toggle) begin
         hold_seen <= hold_toggle;
         hold_left <= hold_len;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, exp_v, act_v);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      flow_result_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (flow_expq.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual status %0d",
                     $realtime, rsp_status);
            errors++;
         end else begin
            e = flow_expq.pop_front();
            check_field("status", e.status, rsp_status);
            check_field("flow_src_ip", e.src_ip, rsp_flow_src_ip);
            check_field("flow_dst_ip", e.dst_ip, rsp_flow_dst_ip);
            check_field("flow_sport", e.sport, rsp_flow_sport);
            check_field("flow_dport", e.dport, rsp_flow_dport);
            check_field("flow_protocol", e.protocol, rsp_flow_protocol);
            check_field("packet_count", e.packets, rsp_packet_count);
            check_field("byte_count", e.bytes, rsp_byte_count);
            check_field("flow_age", e.age, rsp_flow_age);
            check_field("flag_union", e.flags, rsp_flag_union);
         end
      end
   end

   int cycles = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   localparam logic [7:0] FIN = 8'h01 << FLAG_FIN_BIT;
   localparam logic [7:0] SYN = 8'h01 << FLAG_SYN_BIT;

   task automatic test_directed();
      send_item(make_read(6'd0, 1'b1, 1'b1));
      send_item(make_read(6'd63, 1'b1, 1'b1));
      send_item(make_pkt(8'd0, 8'hFF, '1, '1, '1, '1, '1, '1));
      send_item(make_pkt(8'd255, 8'h00, '0, '0, '0, '0, '0, '0));
      // TCP misses without SYN, FIN alone included
      send_item(make_pkt(PROTO_TCP, 8'h10, 32'h0A000001, 32'h0A000002, 16'd80, 16'd81, 16'd60, 64'd5));
      send_item(make_pkt(PROTO_TCP, FIN, 32'h0A000001, 32'h0A000002, 16'd80, 16'd81, 16'd60, 64'd6));
      // SYN with FIN on a miss still creates
      send_item(make_pkt(PROTO_TCP, SYN | FIN, '1, '1, '1, '1, 16'hFFFF, 64'd100));
      send_item(make_pkt(PROTO_UDP, 8'hFF, '0, '0, '0, '0, 16'hFFFF, '1));
      // time going backwards wraps the age
      send_item(make_pkt(PROTO_UDP, 8'hAA, '0, '0, '0, '0, 16'd0, 64'd0));
      send_item(make_pkt(PROTO_TCP, 8'hFC, '1, '1, '1, '1, 16'd1, 64'd700));
      send_item(make_read(6'd0, 1'b1, 1'b0));
      send_item(make_read(6'd1, 1'b1, 1'b0));
      send_item(make_read(6'd1, 1'b0, 1'b1));
      send_item(make_read(6'd0, 1'b0, 1'b1));
      send_item(make_read(6'd0, 1'b0, 1'b0));
      send_item(make_pkt(PROTO_TCP, FIN, '1, '1, '1, '1, 16'd40, 64'd800));
      send_item(make_read(6'd0, 1'b1, 1'b1));
      send_item(make_pkt(PROTO_UDP, 8'h00, 32'h1, '0, '0, '0, 16'd8, 64'd900));
      send_item(make_read(6'd0, 1'b1, 1'b1));
      send_item(make_read(6'd2, 1'b1, 1'b1));
   endtask

   task automatic test_table_full();
      for (int i = 0; i < NUM_SLOTS + 2; i++)
         send_item(make_pkt(PROTO_TCP, SYN, 32'hC0A80000 + i, 32'h08080808,
                            16'(1000 + i), 16'd53, 16'd64, now_ts + i));
      send_item(make_pkt(PROTO_TCP, SYN, 32'h1, 32'h2, 16'd3, 16'd4, 16'd40, now_ts));
      // free two slots; the lower one is refilled first
      send_item(make_pkt(PROTO_TCP, FIN, 32'hC0A80005, 32'h08080808,
                         16'd1005, 16'd53, 16'd40, now_ts));
      send_item(make_pkt(PROTO_TCP, FIN, 32'hC0A80003, 32'h08080808,
                         16'd1003, 16'd53, 16'd40, now_ts));
      send_item(make_pkt(PROTO_TCP, SYN, 32'h5, 32'h6, 16'd7, 16'd8, 16'd40, now_ts + 9));
      send_item(make_read(6'd5, 1'b1, 1'b1));
      send_item(make_read(6'd40, 1'b1, 1'b1));
      wait_flows_idle();
   endtask

   task automatic test_pressure();
      tx_idle_pct = 0;
      hold_len = 400;
      hold_toggle = ~hold_toggle;
      for (int i = 0; i < 6; i++)
         send_item(make_read(i[5:0], 1'b1, 1'b1));
      wait_flows_idle();
   endtask

   task automatic test_random(int tx_pct, int rx_pct, int n);
      pkt_item_type p;
      int k;
      int sel;
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      for (int j = 0; j < n; j++) begin
         sel = $urandom_range(99);
         p = make_pkt(8'($urandom), 8'($urandom), $urandom, $urandom, 16'($urandom),
                      16'($urandom), 16'($urandom), {$urandom, $urandom});
         if (sel < 55) begin
            k = $urandom_range(KEY_POOL - 1);
            now_ts = now_ts + $urandom_range(1, 5000);
            p.src_ip = pool_sip[k];
            p.dst_ip = pool_dip[k];
            p.sport = pool_sp[k];
            p.dport = pool_dp[k];
            p.protocol = pool_proto[k];
            if ($urandom_range(19) != 0) p.timestamp = now_ts;
            case ($urandom_range(9))
               0, 1, 2: p.tcp_flags = (p.tcp_flags | SYN) & ~FIN;
               3:       p.tcp_flags = p.tcp_flags | FIN;
               default: p.tcp_flags = p.tcp_flags & ~FIN;
            endcase
         end else if (sel < 82) begin
            p.func = 1'b1;
            p.entry_index = 6'($urandom);
            p.want_tcp = 1'($urandom);
            p.want_udp = 1'($urandom);
         end else if (sel < 92) begin
            p.protocol = $urandom_range(1) ? PROTO_TCP : PROTO_UDP;
         end
         send_item(p);
      end
      wait_flows_idle();
   endtask

   initial begin
      for (int i = 0; i < NUM_SLOTS; i++) tbl_valid[i] = 1'b0;
      for (int i = 0; i < KEY_POOL; i++) begin
         pool_sip[i] = $urandom;
         pool_dip[i] = $urandom;
         pool_sp[i] = 16'($urandom);
         pool_dp[i] = 16'($urandom);
         pool_proto[i] = $urandom_range(1) ? PROTO_TCP : PROTO_UDP;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      wait_flows_idle();
      test_table_full();
      // clear the table of the fill flows before the random part
      for (int i = 0; i < NUM_SLOTS + 2; i++)
         send_item(make_pkt(PROTO_TCP, FIN, 32'hC0A80000 + i, 32'h08080808,
                            16'(1000 + i), 16'd53, 16'd64, now_ts));
      wait_flows_idle();
      test_pressure();
      test_random(13, 66, 230);
      test_random(66, 13, 230);
      test_random(0, 0, 230);
      if (errors == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
